@@ src/heightmap_bilinear_sampler_macros.svh @@
// Assertion macros used by the height map sampler checker.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

// Checked on every rising edge outside reset.
`define HBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define HBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/hbs_pkg.sv @@
// Shared types, codes and the Q0.16 lerp function of the height map sampler.
`timescale 1ns / 1ps

package hbs_pkg;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Action codes of an input word.
    localparam logic [1:0] ACT_WR_HEIGHT = 2'd0;
    localparam logic [1:0] ACT_WR_ALPHA  = 2'd1;
    localparam logic [1:0] ACT_SAMPLE    = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;
    localparam logic [CFG_IW-1:0] CFG_ALTITUDE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MAP_WIDTH  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_MAP_ROWS   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ALPHA_EN   = 3'd4;

    typedef enum logic [1:0] {
        MODE_NEAR,
        MODE_HORZ,
        MODE_VERT,
        MODE_BIL
    } t_mode;

    // One memory job: a store write or a sample with up to four reads.
    typedef struct packed {
        logic        write;
        logic        alpha;
        logic        oor;
        t_mode       mode;
        logic [1:0]  last;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [16:0] wdata;
    } t_req;

    // Neighbor samples of one sample job, handed to the blend pipeline.
    typedef struct packed {
        logic             oor;
        t_mode            mode;
        logic [15:0]      fx;
        logic [15:0]      fy;
        logic [3:0][16:0] h;
        logic [3:0][16:0] a;
    } t_fetched;

    // (a*(1-t) + b*t + 0.5) in Q0.16, written as a + (b-a)*t with one multiplier.
    function automatic logic [16:0] lerp_q16(input logic [16:0] a, input logic [16:0] b,
                                             input logic [15:0] t);
        logic signed [17:0] diff;
        logic signed [35:0] prod;
        logic signed [35:0] acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, t});
        acc  = $signed({3'b000, a, 16'h0000}) + prod + 36'sd32768;
        return acc[32:16];
    endfunction

endpackage

@@ src/hbs_front.sv @@
// Coordinate pipeline: clamp and scale, base index, edge decisions and read or write addresses.
`timescale 1ns / 1ps

module hbs_front #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_ROWS  = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_action,
    input  logic [15:0]               i_entry_index,
    input  logic [16:0]               i_entry_value,
    input  logic [16:0]               i_coord_u,
    input  logic [16:0]               i_coord_v,
    input  logic                      i_precise,
    input  logic [8:0]                i_map_width,
    input  logic [8:0]                i_map_rows,
    output logic                      o_req_valid,
    input  logic                      i_req_stall,
    output hbs_pkg::t_req             o_req,
    output logic [3:0][$clog2(MAX_WIDTH*MAX_ROWS)-1:0] o_req_addr
);

    localparam int DEPTH = MAX_WIDTH * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = ($clog2(DEPTH + 1) > 19) ? $clog2(DEPTH + 1) : 19;

    logic a_en, b_en, c_en, in_take, keep, wr_ok;
    logic [16:0] u_cl, v_cl;

    // Stage A: clamped coordinates scaled by the map size.
    logic        r_a_valid;
    logic        r_a_write, r_a_alpha, r_a_precise;
    logic [15:0] r_a_idx;
    logic [16:0] r_a_val;
    logic [25:0] r_a_posx, r_a_posy;
    logic [25:0] n_a_posx, n_a_posy;

    // Stage B: base index and entry count.
    logic          r_b_valid;
    logic          r_b_write, r_b_alpha, r_b_precise;
    logic [15:0]   r_b_idx;
    logic [16:0]   r_b_val;
    logic [18:0]   r_b_base;
    logic [CW-1:0] r_b_n;
    logic [8:0]    r_b_px, r_b_py;
    logic [15:0]   r_b_fx, r_b_fy;
    logic [18:0]   n_b_base;
    logic [17:0]   n_raw;
    logic [CW-1:0] n_b_n;

    // Stage C: job for the memory sequencer.
    logic                r_c_valid;
    hbs_pkg::t_req       r_c_req;
    logic [3:0][AW-1:0]  r_c_addr;
    hbs_pkg::t_req       n_c_req;
    logic [3:0][AW-1:0]  n_c_addr;

    logic [CW-1:0] b, w, s1, s2, s3, idx_w;
    logic x_ok, y_ok, oor, bil, hor, ver;
    hbs_pkg::t_mode mode;

    assign c_en       = !r_c_valid || !i_req_stall;
    assign b_en       = !r_b_valid || c_en;
    assign a_en       = !r_a_valid || b_en;
    assign o_in_stall = !a_en;
    assign in_take    = i_in_valid && a_en;

    // Writes beyond the store and unknown actions are accepted and dropped.
    assign wr_ok = ((i_action == hbs_pkg::ACT_WR_HEIGHT) || (i_action == hbs_pkg::ACT_WR_ALPHA))
                   && (32'(i_entry_index) < 32'(DEPTH));
    assign keep  = wr_ok || (i_action == hbs_pkg::ACT_SAMPLE);

    assign u_cl     = (i_coord_u > hbs_pkg::ONE_Q16) ? hbs_pkg::ONE_Q16 : i_coord_u;
    assign v_cl     = (i_coord_v > hbs_pkg::ONE_Q16) ? hbs_pkg::ONE_Q16 : i_coord_v;
    assign n_a_posx = 26'(i_map_width) * 26'(u_cl);
    assign n_a_posy = 26'(i_map_rows) * 26'(v_cl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_en) begin
            r_a_valid <= in_take && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_en) begin
            r_a_write   <= (i_action != hbs_pkg::ACT_SAMPLE);
            r_a_alpha   <= (i_action == hbs_pkg::ACT_WR_ALPHA);
            r_a_idx     <= i_entry_index;
            r_a_val     <= i_entry_value;
            r_a_precise <= i_precise;
            r_a_posx    <= n_a_posx;
            r_a_posy    <= n_a_posy;
        end
    end

    assign n_b_base = 19'(r_a_posy[24:16]) * 19'(i_map_width) + 19'(r_a_posx[24:16]);
    assign n_raw    = 18'(i_map_width) * 18'(i_map_rows);
    assign n_b_n    = (CW'(n_raw) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(n_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b_write   <= r_a_write;
            r_b_alpha   <= r_a_alpha;
            r_b_idx     <= r_a_idx;
            r_b_val     <= r_a_val;
            r_b_precise <= r_a_precise;
            r_b_base    <= n_b_base;
            r_b_n       <= n_b_n;
            r_b_px      <= r_a_posx[24:16];
            r_b_py      <= r_a_posy[24:16];
            r_b_fx      <= r_a_posx[15:0];
            r_b_fy      <= r_a_posy[15:0];
        end
    end

    assign b     = CW'(r_b_base);
    assign w     = CW'(i_map_width);
    assign s1    = b + CW'(1);
    assign s2    = b + w;
    assign s3    = s2 + CW'(1);
    assign idx_w = CW'(r_b_idx);

    assign oor  = (b >= r_b_n);
    assign x_ok = (10'(r_b_px) + 10'd1) < 10'(i_map_width);
    assign y_ok = (10'(r_b_py) + 10'd1) < 10'(i_map_rows);
    assign bil  = (r_b_fx != 16'd0) && (r_b_fy != 16'd0) && x_ok && y_ok && (s3 < r_b_n);
    assign hor  = (r_b_fx != 16'd0) && x_ok && (s1 < r_b_n);
    assign ver  = (r_b_fy != 16'd0) && (s2 < r_b_n);

    always_comb begin
        if (!r_b_precise || oor) begin
            mode = hbs_pkg::MODE_NEAR;
        end else if (bil) begin
            mode = hbs_pkg::MODE_BIL;
        end else if (hor) begin
            mode = hbs_pkg::MODE_HORZ;
        end else if (ver) begin
            mode = hbs_pkg::MODE_VERT;
        end else begin
            mode = hbs_pkg::MODE_NEAR;
        end
    end

    always_comb begin
        n_c_req.write = r_b_write;
        n_c_req.alpha = r_b_alpha;
        n_c_req.oor   = oor;
        n_c_req.mode  = mode;
        n_c_req.fx    = r_b_fx;
        n_c_req.fy    = r_b_fy;
        n_c_req.wdata = r_b_val;
        case (mode)
            hbs_pkg::MODE_BIL:  n_c_req.last = 2'd3;
            hbs_pkg::MODE_HORZ: n_c_req.last = 2'd1;
            hbs_pkg::MODE_VERT: n_c_req.last = 2'd1;
            default:            n_c_req.last = 2'd0;
        endcase
        // Reads are issued in slot order; the vertical lerp takes its second
        // sample from the row below.
        n_c_addr[0] = r_b_write ? idx_w[AW-1:0] : b[AW-1:0];
        n_c_addr[1] = (mode == hbs_pkg::MODE_VERT) ? s2[AW-1:0] : s1[AW-1:0];
        n_c_addr[2] = s2[AW-1:0];
        n_c_addr[3] = s3[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_c_req  <= n_c_req;
            r_c_addr <= n_c_addr;
        end
    end

    assign o_req_valid = r_c_valid;
    assign o_req       = r_c_req;
    assign o_req_addr  = r_c_addr;

endmodule

@@ src/hbs_fetch.sv @@
// Height and alpha stores with the sequencer that writes them and gathers neighbor samples.
`timescale 1ns / 1ps

module hbs_fetch #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_ROWS  = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_stall,
    input  hbs_pkg::t_req        i_req,
    input  logic [3:0][$clog2(MAX_WIDTH*MAX_ROWS)-1:0] i_req_addr,
    output logic                 o_fet_valid,
    input  logic                 i_fet_take,
    output hbs_pkg::t_fetched    o_fet
);

    localparam int DEPTH = MAX_WIDTH * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [16:0] mem_h [DEPTH];
    logic [16:0] mem_a [DEPTH];
    logic [16:0] r_q_h, r_q_a;

    // Sequencer: one store access per cycle while a finished read set is not held back.
    logic               r_s_valid;
    logic [1:0]         r_s_cnt;
    hbs_pkg::t_req      r_s_req;
    logic [3:0][AW-1:0] r_s_addr;

    // Read in flight: its data sits in r_q_* in the cycle after issue.
    logic          r_p_valid;
    logic          r_p_last;
    logic [1:0]    r_p_slot;
    hbs_pkg::t_req r_p_req;

    logic [16:0] r_ch [3];
    logic [16:0] r_ca [3];

    logic              r_o_valid;
    hbs_pkg::t_fetched r_o;
    hbs_pkg::t_fetched n_o;

    logic handoff_free, blocked, issue, s_last, s_done, load, we_h, we_a, re, complete;
    logic [AW-1:0] mem_addr;

    assign handoff_free = !r_o_valid || i_fet_take;
    // A finished read set that cannot be handed over holds the store port so
    // that its last word stays in the read register.
    assign blocked  = r_p_valid && r_p_last && !handoff_free;
    assign issue    = r_s_valid && !blocked;
    assign s_last   = r_s_req.write || (r_s_cnt == r_s_req.last);
    assign s_done   = issue && s_last;
    assign load     = i_req_valid && (!r_s_valid || s_done);
    assign complete = r_p_valid && r_p_last && handoff_free;

    assign o_req_stall = r_s_valid && !s_done;

    assign mem_addr = r_s_addr[r_s_cnt];
    assign we_h     = issue && r_s_req.write && !r_s_req.alpha;
    assign we_a     = issue && r_s_req.write && r_s_req.alpha;
    assign re       = issue && !r_s_req.write;

    always_ff @(posedge i_clk) begin
        if (we_h) begin
            mem_h[mem_addr] <= r_s_req.wdata;
        end
        if (re) begin
            r_q_h <= mem_h[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[mem_addr] <= r_s_req.wdata;
        end
        if (re) begin
            r_q_a <= mem_a[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_s_cnt   <= 2'd0;
        end else begin
            if (load) begin
                r_s_valid <= 1'b1;
            end else if (s_done) begin
                r_s_valid <= 1'b0;
            end
            if (load) begin
                r_s_cnt <= 2'd0;
            end else if (issue) begin
                r_s_cnt <= r_s_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s_req  <= i_req;
            r_s_addr <= i_req_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (!blocked) begin
            r_p_valid <= re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_p_slot <= r_s_cnt;
            r_p_last <= s_last;
            r_p_req  <= r_s_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid && !r_p_last) begin
            r_ch[r_p_slot] <= r_q_h;
            r_ca[r_p_slot] <= r_q_a;
        end
    end

    always_comb begin
        n_o.oor  = r_p_req.oor;
        n_o.mode = r_p_req.mode;
        n_o.fx   = r_p_req.fx;
        n_o.fy   = r_p_req.fy;
        for (int i = 0; i < 3; i++) begin
            n_o.h[i] = (r_p_slot == 2'(i)) ? r_q_h : r_ch[i];
            n_o.a[i] = (r_p_slot == 2'(i)) ? r_q_a : r_ca[i];
        end
        // The fourth neighbor is only ever the last read.
        n_o.h[3] = r_q_h;
        n_o.a[3] = r_q_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (complete) begin
            r_o_valid <= 1'b1;
        end else if (i_fet_take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_o <= n_o;
        end
    end

    assign o_fet_valid = r_o_valid;
    assign o_fet       = r_o;

endmodule

@@ src/hbs_blend.sv @@
// Blend pipeline: row lerps, column lerp, height scaling and the output register.
`timescale 1ns / 1ps

module hbs_blend (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fet_valid,
    output logic                     o_fet_take,
    input  hbs_pkg::t_fetched        i_fet,
    input  logic signed [23:0]       i_altitude,
    input  logic [22:0]              i_map_height,
    input  logic                     i_alpha_en,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [41:0]       o_height_out,
    output logic [16:0]              o_intensity,
    output logic                     o_in_range
);

    logic e1, e2, e3, e4;

    logic           r_st1_valid, r_st1_oor;
    hbs_pkg::t_mode r_st1_mode;
    logic [15:0]    r_st1_fy;
    logic [16:0]    r_st1_top_h, r_st1_bot_h, r_st1_top_a, r_st1_bot_a;
    logic [15:0]    t_top;
    logic [16:0]    n_st1_top_h, n_st1_bot_h, n_st1_top_a, n_st1_bot_a;

    logic        r_st2_valid, r_st2_oor;
    logic [16:0] r_st2_h, r_st2_a;
    logic [16:0] n_st2_h, n_st2_a;

    logic        r_st3_valid, r_st3_oor;
    logic [39:0] r_st3_prod;
    logic [16:0] r_st3_inten;
    logic [39:0] n_st3_prod;
    logic [16:0] n_st3_inten;

    logic               r_st4_valid, r_st4_in_range;
    logic signed [41:0] r_st4_height;
    logic [16:0]        r_st4_inten;
    logic signed [41:0] n_st4_height;

    assign e4 = !r_st4_valid || !i_out_stall;
    assign e3 = !r_st3_valid || e4;
    assign e2 = !r_st2_valid || e3;
    assign e1 = !r_st1_valid || e2;
    assign o_fet_take = e1;

    // Row lerps; a vertical edge case uses the top lane with the v fraction.
    assign t_top       = (i_fet.mode == hbs_pkg::MODE_VERT) ? i_fet.fy : i_fet.fx;
    assign n_st1_top_h = (i_fet.mode == hbs_pkg::MODE_NEAR) ? i_fet.h[0]
                       : hbs_pkg::lerp_q16(i_fet.h[0], i_fet.h[1], t_top);
    assign n_st1_top_a = (i_fet.mode == hbs_pkg::MODE_NEAR) ? i_fet.a[0]
                       : hbs_pkg::lerp_q16(i_fet.a[0], i_fet.a[1], t_top);
    assign n_st1_bot_h = hbs_pkg::lerp_q16(i_fet.h[2], i_fet.h[3], i_fet.fx);
    assign n_st1_bot_a = hbs_pkg::lerp_q16(i_fet.a[2], i_fet.a[3], i_fet.fx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1_valid <= 1'b0;
        end else if (e1) begin
            r_st1_valid <= i_fet_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r_st1_oor   <= i_fet.oor;
            r_st1_mode  <= i_fet.mode;
            r_st1_fy    <= i_fet.fy;
            r_st1_top_h <= n_st1_top_h;
            r_st1_bot_h <= n_st1_bot_h;
            r_st1_top_a <= n_st1_top_a;
            r_st1_bot_a <= n_st1_bot_a;
        end
    end

    assign n_st2_h = (r_st1_mode == hbs_pkg::MODE_BIL)
                   ? hbs_pkg::lerp_q16(r_st1_top_h, r_st1_bot_h, r_st1_fy)
                   : r_st1_top_h;
    assign n_st2_a = (r_st1_mode == hbs_pkg::MODE_BIL)
                   ? hbs_pkg::lerp_q16(r_st1_top_a, r_st1_bot_a, r_st1_fy)
                   : r_st1_top_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st2_valid <= 1'b0;
        end else if (e2) begin
            r_st2_valid <= r_st1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e2) begin
            r_st2_oor <= r_st1_oor;
            r_st2_h   <= n_st2_h;
            r_st2_a   <= n_st2_a;
        end
    end

    assign n_st3_prod  = 40'(r_st2_h) * 40'(i_map_height);
    assign n_st3_inten = r_st2_oor ? 17'd0 : (i_alpha_en ? r_st2_a : hbs_pkg::ONE_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st3_valid <= 1'b0;
        end else if (e3) begin
            r_st3_valid <= r_st2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e3) begin
            r_st3_oor   <= r_st2_oor;
            r_st3_prod  <= n_st3_prod;
            r_st3_inten <= n_st3_inten;
        end
    end

    assign n_st4_height = r_st3_oor ? 42'sd0
                        : 42'($signed({i_altitude, 16'h0000})) + $signed({2'b00, r_st3_prod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st4_valid <= 1'b0;
        end else if (e4) begin
            r_st4_valid <= r_st3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e4) begin
            r_st4_height   <= n_st4_height;
            r_st4_inten    <= r_st3_inten;
            r_st4_in_range <= !r_st3_oor;
        end
    end

    assign o_out_valid  = r_st4_valid;
    assign o_height_out = r_st4_height;
    assign o_intensity  = r_st4_inten;
    assign o_in_range   = r_st4_in_range;

endmodule

@@ src/heightmap_bilinear_sampler.sv @@
// Top level of the height map bilinear sampler: configuration registers and the three parts.
// Write words load one entry of the height or alpha store and occupy the shared store
// port. A sample word reads one, two or four neighbors through that port: one for the
// nearest pixel or a position outside the map, two for a lerp along an edge, four for a
// full bilinear sample, so its rate is set by the number of neighbors read from the
// single-port stores. Words follow each other back to back while nothing stalls, and a
// result is offered after its word has passed the front stages, the store reads and the
// blend stages. An entry must be written before a sample reads it. The user must write
// configuration only while no word is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_ROWS  = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hbs_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  logic [hbs_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic [15:0]                 i_entry_index,
    input  logic [16:0]                 i_entry_value,
    input  logic [16:0]                 i_coord_u,
    input  logic [16:0]                 i_coord_v,
    input  logic                        i_precise,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [41:0]          o_height_out,
    output logic [16:0]                 o_intensity,
    output logic                        o_in_range
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_ROWS);

    logic signed [23:0] r_altitude;
    logic [22:0]        r_map_height;
    logic [8:0]         r_map_width;
    logic [8:0]         r_map_rows;
    logic               r_alpha_en;

    logic               req_valid, req_stall, fet_valid, fet_take;
    hbs_pkg::t_req      req;
    logic [3:0][AW-1:0] req_addr;
    hbs_pkg::t_fetched  fet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_altitude   <= 24'sd0;
            r_map_height <= 23'd0;
            r_map_width  <= 9'd256;
            r_map_rows   <= 9'd256;
            r_alpha_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hbs_pkg::CFG_ALTITUDE:   r_altitude   <= $signed(i_cfg_data);
                hbs_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[22:0];
                hbs_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[8:0];
                hbs_pkg::CFG_MAP_ROWS:   r_map_rows   <= i_cfg_data[8:0];
                hbs_pkg::CFG_ALPHA_EN:   r_alpha_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    hbs_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .i_precise     (i_precise),
        .i_map_width   (r_map_width),
        .i_map_rows    (r_map_rows),
        .o_req_valid   (req_valid),
        .i_req_stall   (req_stall),
        .o_req         (req),
        .o_req_addr    (req_addr)
    );

    hbs_fetch #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_fetch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .i_req_addr  (req_addr),
        .o_fet_valid (fet_valid),
        .i_fet_take  (fet_take),
        .o_fet       (fet)
    );

    hbs_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fet_valid  (fet_valid),
        .o_fet_take   (fet_take),
        .i_fet        (fet),
        .i_altitude   (r_altitude),
        .i_map_height (r_map_height),
        .i_alpha_en   (r_alpha_en),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_height_out (o_height_out),
        .o_intensity  (o_intensity),
        .o_in_range   (o_in_range)
    );

endmodule

@@ src/hbs_checker.sv @@
// Port-level checker of the height map sampler and its bind to the top level.
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_macros.svh"

module hbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [41:0] o_height_out,
    input logic [16:0]        o_intensity,
    input logic               o_in_range
);

    // A result word that is held back stays offered.
    `HBS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result word dropped while stalled")

    // A position outside the map reports zero height and zero intensity.
    `HBS_ASSERT(a_oor_zero, i_clk, i_rst_n, o_out_valid && !o_in_range |-> (o_height_out == 42'sd0) && (o_intensity == 17'd0), "outside result not zero")

    // Reset empties the pipeline, so nothing is offered right after it.
    `HBS_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid, "result offered after reset")

    // The input side is open right after reset.
    `HBS_ASSERT_ALWAYS(a_rst_in, i_clk, !i_rst_n |=> !o_in_stall, "input stalled after reset")

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_height_out (o_height_out),
    .o_intensity  (o_intensity),
    .o_in_range   (o_in_range)
);
